// ===== rtl/lphs_pkg.sv =====
// lphs_pkg: shared types and constants of the linear probing hash set
// field widths, operation and status codes, sequencer states, command/status structs
// no dependencies
package lphs_pkg;

  localparam int KEY_W  = 31;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 11;
  localparam int MOD_W  = 11;
  localparam int BIT_W  = 5;
  localparam logic [MOD_W-1:0] MOD_RESET = 11'd1024;

  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_ABSENT   = 2'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ADDED    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_RD,
    S_CHK,
    S_WRD,
    S_WCHK,
    S_PHOME,
    S_PRD,
    S_PCHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              clr_en;
    logic              cfg_load;
    logic              op_load;
    logic              div_moved;
    logic              pos_from_rem;
    logic              pos_next;
    logic              rd_walk;
    logic              wr_clear_pos;
    logic              wr_clear_walk;
    logic              wr_fill_key;
    logic              wr_fill_moved;
    logic              occ_inc;
    logic              occ_dec;
    logic              walk_init;
    logic              walk_next;
    logic              st_we;
    logic [STAT_W-1:0] st;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic              clr_done;
    logic              div_done;
    logic              rd_valid;
    logic              rd_hit;
    logic              last;
    logic              walk_end;
    logic [FUNC_W-1:0] func;
    logic              out_busy;
  } stat_t;

endpackage

// ===== rtl/lphs_in_if.sv =====
// lphs_in_if: request channel (func, key) with valid/ready
// depends on lphs_pkg
interface lphs_in_if import lphs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;
  modport source (output valid, func, key, input ready);
  modport sink (input valid, func, key, output ready);
endinterface

// ===== rtl/lphs_out_if.sv =====
// lphs_out_if: result channel (status, occupancy) with valid/ready
// depends on lphs_pkg
interface lphs_out_if import lphs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [OCC_W-1:0]  occupancy;
  modport source (output valid, status, occupancy, input ready);
  modport sink (input valid, status, occupancy, output ready);
endinterface

// ===== rtl/lphs_cfg_if.sv =====
// lphs_cfg_if: configuration write channel for table_modulus
// depends on lphs_pkg
interface lphs_cfg_if import lphs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/lphs_ram.sv =====
// lphs_ram: generic single-port ram with registered read
// no dependencies
module lphs_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lphs_rem.sv =====
// lphs_rem: bit-serial remainder of a key by the active table size
// depends on lphs_pkg
module lphs_rem import lphs_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [KEY_W-1:0]           dividend,
  input  logic [$clog2(SLOTS+1)-1:0] divisor,
  output logic                       done,
  output logic [$clog2(SLOTS)-1:0]   rem
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);

  logic [KEY_W-1:0] sh_r, sh_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [BIT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [CW:0]      trial;

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, sh_r[KEY_W-1]};
    if (start) begin
      sh_nxt   = dividend;
      rem_nxt  = '0;
      cnt_nxt  = BIT_W'(KEY_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one quotient bit a cycle, remainder stays below the divisor
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_nxt = trial[CW-1:0];
      sh_nxt  = {sh_r[KEY_W-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = !busy_r;
  assign rem  = rem_r[IW-1:0];

endmodule

// ===== rtl/lphs_dp.sv =====
// lphs_dp: datapath of the hash set: slot ram, probe and walk pointers, counts, output register
// depends on lphs_pkg, lphs_ram, lphs_rem
module lphs_dp import lphs_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [MOD_W-1:0]  cfg_data,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [KEY_W-1:0]  in_key,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [OCC_W-1:0]  out_occupancy
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int MW = (CW > MOD_W) ? CW : MOD_W;

  logic [MOD_W-1:0]  mod_r;
  logic [FUNC_W-1:0] func_r;
  logic [KEY_W-1:0]  key_r, moved_r;
  logic [IW-1:0]     pos_r, walk_pos_r, clr_r, probe_cnt_r;
  logic [CW-1:0]     walk_cnt_r, occ_r;
  logic [STAT_W-1:0] st_r, out_status_r;
  logic [OCC_W-1:0]  out_occ_r;
  logic              out_valid_r;

  logic [MW-1:0]     mod_ext;
  logic [CW-1:0]     m;
  logic [IW-1:0]     pos_inc, walk_inc, rem;
  logic              div_done;
  logic              ram_we;
  logic [IW-1:0]     ram_addr;
  logic [KEY_W:0]    ram_wdata, ram_rdata;

  // active size: zero acts as one, above the capacity acts as the capacity
  always_comb begin
    mod_ext = MW'(mod_r);
    if (mod_ext == '0) begin
      m = CW'(1);
    end else if (mod_ext > MW'(SLOTS)) begin
      m = CW'(SLOTS);
    end else begin
      m = mod_ext[CW-1:0];
    end
  end

  // wrap from the last active slot to slot 0
  always_comb begin
    pos_inc  = ({1'b0, pos_r} + 1'b1 >= {1'b0, m}) ? '0 : pos_r + 1'b1;
    walk_inc = ({1'b0, walk_pos_r} + 1'b1 >= {1'b0, m}) ? '0 : walk_pos_r + 1'b1;
  end

  lphs_rem #(.SLOTS(SLOTS)) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.op_load | cmd.div_moved),
    .dividend(cmd.op_load ? in_key : ram_rdata[KEY_W-1:0]),
    .divisor (m),
    .done    (div_done),
    .rem     (rem)
  );

  always_comb begin
    ram_we = cmd.clr_en | cmd.wr_clear_pos | cmd.wr_clear_walk
           | cmd.wr_fill_key | cmd.wr_fill_moved;
    if (cmd.clr_en) begin
      ram_addr = clr_r;
    end else if (cmd.rd_walk | cmd.wr_clear_walk) begin
      ram_addr = walk_pos_r;
    end else begin
      ram_addr = pos_r;
    end
    if (cmd.wr_fill_key) begin
      ram_wdata = {1'b1, key_r};
    end else if (cmd.wr_fill_moved) begin
      ram_wdata = {1'b1, moved_r};
    end else begin
      ram_wdata = '0;
    end
  end

  // valid mark kept in the top bit of each slot word
  lphs_ram #(.W(KEY_W + 1), .D(SLOTS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= MOD_RESET;
      occ_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cfg_load) begin
        mod_r <= cfg_data;
        occ_r <= '0;
      end else if (cmd.occ_inc) begin
        occ_r <= occ_r + 1'b1;
      end else if (cmd.occ_dec && occ_r != '0) begin
        occ_r <= occ_r - 1'b1;
      end
      if (cmd.clr_en) begin
        clr_r <= (clr_r == IW'(SLOTS - 1)) ? '0 : clr_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      func_r <= in_func;
      key_r  <= in_key;
    end
    if (cmd.div_moved) begin
      moved_r <= ram_rdata[KEY_W-1:0];
    end
    if (cmd.pos_from_rem) begin
      pos_r       <= rem;
      probe_cnt_r <= '0;
    end else if (cmd.pos_next) begin
      pos_r       <= pos_inc;
      probe_cnt_r <= probe_cnt_r + 1'b1;
    end
    if (cmd.walk_init) begin
      walk_pos_r <= pos_inc;
      walk_cnt_r <= '0;
    end else if (cmd.walk_next) begin
      walk_pos_r <= walk_inc;
      walk_cnt_r <= walk_cnt_r + 1'b1;
    end
    if (cmd.st_we) begin
      st_r <= cmd.st;
    end
    if (cmd.out_load) begin
      out_status_r <= st_r;
      out_occ_r    <= OCC_W'(occ_r);
    end
  end

  always_comb begin
    stat.clr_done = (clr_r == IW'(SLOTS - 1));
    stat.div_done = div_done;
    stat.rd_valid = ram_rdata[KEY_W];
    stat.rd_hit   = ram_rdata[KEY_W] && (ram_rdata[KEY_W-1:0] == key_r);
    stat.last     = ({1'b0, probe_cnt_r} + 1'b1 == {1'b0, m});
    stat.walk_end = (walk_cnt_r == m);
    stat.func     = func_r;
    stat.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

endmodule

// ===== rtl/lphs_ctrl.sv =====
// lphs_ctrl: sequencer for search, insert, remove with cluster re-insertion
// depends on lphs_pkg
module lphs_ctrl import lphs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_load = 1'b1;
          state_nxt    = S_CLEAR;
        end else if (in_valid) begin
          cmd.op_load = 1'b1;
          state_nxt   = S_HOME;
        end
      end
      S_HOME: begin
        if (stat.div_done) begin
          cmd.pos_from_rem = 1'b1;
          state_nxt        = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.rd_hit) begin
          if (stat.func == FN_REMOVE) begin
            cmd.wr_clear_pos = 1'b1;
            cmd.occ_dec      = 1'b1;
            cmd.walk_init    = 1'b1;
            state_nxt        = S_WRD;
          end else begin
            cmd.st_we = 1'b1;
            cmd.st    = ST_PRESENT;
            state_nxt = S_RESP;
          end
        end else if (!stat.rd_valid || stat.last) begin
          cmd.st_we = 1'b1;
          state_nxt = S_RESP;
          case (stat.func)
            FN_INSERT: begin
              if (!stat.rd_valid) begin
                cmd.wr_fill_key = 1'b1;
                cmd.occ_inc     = 1'b1;
                cmd.st          = ST_ADDED;
              end else begin
                cmd.st = ST_FULL;
              end
            end
            FN_REMOVE: cmd.st = ST_NOTFOUND;
            default:   cmd.st = ST_ABSENT;
          endcase
        end else begin
          cmd.pos_next = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_WRD: begin
        if (stat.walk_end) begin
          cmd.st_we = 1'b1;
          cmd.st    = ST_REMOVED;
          state_nxt = S_RESP;
        end else begin
          cmd.rd_walk = 1'b1;
          state_nxt   = S_WCHK;
        end
      end
      S_WCHK: begin
        if (!stat.rd_valid) begin
          cmd.st_we = 1'b1;
          cmd.st    = ST_REMOVED;
          state_nxt = S_RESP;
        end else begin
          // lift the entry out and find its new place from its home
          cmd.div_moved     = 1'b1;
          cmd.wr_clear_walk = 1'b1;
          cmd.occ_dec       = 1'b1;
          state_nxt         = S_PHOME;
        end
      end
      S_PHOME: begin
        if (stat.div_done) begin
          cmd.pos_from_rem = 1'b1;
          state_nxt        = S_PRD;
        end
      end
      S_PRD: begin
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (!stat.rd_valid) begin
          cmd.wr_fill_moved = 1'b1;
          cmd.occ_inc       = 1'b1;
          cmd.walk_next     = 1'b1;
          state_nxt         = S_WRD;
        end else begin
          cmd.pos_next = 1'b1;
          state_nxt    = S_PRD;
        end
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/linear_probe_hash_set.sv =====
// linear_probe_hash_set: set of 31-bit keys in an open-addressing table with linear probing
// depends on lphs_pkg, lphs_in_if, lphs_out_if, lphs_cfg_if, lphs_ctrl, lphs_dp
//
// usage:
//   in_chan carries one request (func: search, insert, remove; key) per transaction.
//   out_chan returns one result per request: status and the occupancy after it.
//   cfg_chan writes table_modulus (slots in use); a write also empties the set.
// operation:
//   a request first finds its home slot with the serial remainder unit, then
//   reads slots one after another through the single ram port (registered read),
//   then loads the result register. a remove then takes each following entry
//   of its cluster out and re-inserts it from its home slot, probing as above.
//   one request is in work at a time.
// reset and stalls:
//   after reset, and after every configuration write, a clearing pass writes
//   every slot empty; no request is taken meanwhile.
//   a finished result waits in the output register while out_chan.ready is low;
//   the next request is still accepted, but its result waits until that one leaves.
module linear_probe_hash_set import lphs_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  lphs_in_if.sink    in_chan,
  lphs_out_if.source out_chan,
  lphs_cfg_if.sink   cfg_chan
);

  cmd_t  cmd;
  stat_t stat;

  lphs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cfg_valid(cfg_chan.valid),
    .cfg_ready(cfg_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lphs_dp #(.SLOTS(SLOTS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_data     (cfg_chan.data),
    .in_func      (in_chan.func),
    .in_key       (in_chan.key),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .out_status   (out_chan.status),
    .out_occupancy(out_chan.occupancy)
  );

endmodule

// ===== tb/linear_probe_hash_set_tb.sv =====
// linear_probe_hash_set_tb: self-checking bench for the linear probing hash set
// drives requests and modulus writes, predicts status and occupancy, checks every result
// depends on lphs_pkg, lphs_in_if, lphs_out_if, lphs_cfg_if and linear_probe_hash_set
module linear_probe_hash_set_tb;
  import lphs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 1024;
  localparam int CYCLE_MAX  = 4000000;
  localparam int PHASE_REQS = 165;
  localparam logic [KEY_W-1:0] KEY_TOP = 31'h7FFF_FFFE;
  // unused operation code, behaves as a search
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;
  } answer_t;

  typedef struct {
    bit                is_cfg;
    logic [MOD_W-1:0]  modulus;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    bit                fixed;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  lphs_in_if  req_if ();
  lphs_out_if res_if ();
  lphs_cfg_if cfg_if ();

  linear_probe_hash_set #(.SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if),
    .cfg_chan (cfg_if)
  );

  always #6 clk = ~clk;

  // shadow copy of the table
  bit [KEY_W-1:0] shadow_key [SLOTS];
  bit             shadow_used [SLOTS];
  int unsigned    shadow_count;
  int unsigned    shadow_size;

  answer_t        awaited_answers [$];
  logic [KEY_W-1:0] live_keys [$];
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  bit             calm = 1'b0;
  int unsigned    stall_left = 0;
  plan_row_t      plan [$];

  function automatic int unsigned step_slot(int unsigned p);
    return (p + 1 >= shadow_size) ? 0 : p + 1;
  endfunction

  function automatic bit find_key(logic [KEY_W-1:0] k, output int unsigned at);
    int unsigned p;
    p  = k % shadow_size;
    at = 0;
    for (int unsigned i = 0; i < shadow_size; i++) begin
      if (!shadow_used[p]) return 1'b0;
      if (shadow_key[p] == k) begin
        at = p;
        return 1'b1;
      end
      p = step_slot(p);
    end
    return 1'b0;
  endfunction

  function automatic void store_key(logic [KEY_W-1:0] k);
    int unsigned p;
    p = k % shadow_size;
    for (int unsigned i = 0; i < shadow_size; i++) begin
      if (!shadow_used[p]) begin
        shadow_used[p] = 1'b1;
        shadow_key[p]  = k;
        shadow_count++;
        return;
      end
      p = step_slot(p);
    end
  endfunction

  function automatic void empty_table(logic [MOD_W-1:0] m);
    shadow_size = (m == 0) ? 1 : ((m > SLOTS) ? SLOTS : m);
    foreach (shadow_used[i]) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
    end
    shadow_count = 0;
  endfunction

  function automatic answer_t apply_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k);
    answer_t     a;
    int unsigned at;
    int unsigned p;
    bit          hit;
    logic [KEY_W-1:0] moved;
    hit = find_key(k, at);
    if (f == FN_INSERT) begin
      if (hit) a.status = ST_PRESENT;
      else if (shadow_count >= shadow_size) a.status = ST_FULL;
      else begin
        store_key(k);
        a.status = ST_ADDED;
      end
    end else if (f == FN_REMOVE) begin
      if (!hit) a.status = ST_NOTFOUND;
      else begin
        shadow_used[at] = 1'b0;
        shadow_count--;
        // pull the rest of the cluster out and put it back
        p = step_slot(at);
        for (int unsigned i = 0; i < shadow_size && shadow_used[p]; i++) begin
          moved = shadow_key[p];
          shadow_used[p] = 1'b0;
          shadow_count--;
          store_key(moved);
          p = step_slot(p);
        end
        a.status = ST_REMOVED;
      end
    end else begin
      a.status = hit ? ST_PRESENT : ST_ABSENT;
    end
    a.occupancy = shadow_count[OCC_W-1:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one request transaction; valid stays high when the next one follows at once
  task automatic send_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k, bit fixed,
                              answer_t typed);
    int unsigned gap;
    answer_t     a;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= f;
    req_if.key   <= k;
    do @(posedge clk); while (!req_if.ready);
    a = apply_request(f, k);
    awaited_answers.push_back(fixed ? typed : a);
    if (f == FN_INSERT && a.status == ST_ADDED) begin
      live_keys.push_back(k);
      if (live_keys.size() > 64) void'(live_keys.pop_front());
    end
  endtask

  task automatic write_modulus(logic [MOD_W-1:0] m);
    req_if.valid <= 1'b0;
    wait (awaited_answers.size() == 0);
    repeat (40) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= m;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    empty_table(m);
    live_keys.delete();
  endtask

  function automatic logic [KEY_W-1:0] draw_key();
    int unsigned r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 5) k = $urandom_range(0, 1) ? KEY_TOP : '0;
    else if (r < 20) begin
      k = KEY_W'($urandom);
      if (k == 31'h7FFF_FFFF) k = KEY_TOP;
    end else if (r < 60 && live_keys.size() > 0) begin
      k = live_keys[$urandom_range(0, live_keys.size() - 1)];
    end else begin
      k = KEY_W'($urandom_range(0, 3) * shadow_size + $urandom_range(0, shadow_size - 1));
    end
    return k;
  endfunction

  function automatic logic [FUNC_W-1:0] draw_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return FN_INSERT;
    if (r < 70) return FN_SEARCH;
    if (r < 95) return FN_REMOVE;
    return FN_SPARE;
  endfunction

  // result side: random back-pressure and the check against the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (awaited_answers.size() == 0) begin
          $display("unexpected result status %0d occupancy %0d at cycle %0d",
                   res_if.status, res_if.occupancy, cycle_count);
          error_count++;
        end else begin
          want = awaited_answers.pop_front();
          if (res_if.status !== want.status)
            report_mismatch("status", res_if.status, want.status);
          if (res_if.occupancy !== want.occupancy)
            report_mismatch("occupancy", res_if.occupancy, want.occupancy);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res_if.ready <= 1'b0;
      end else if (calm) begin
        res_if.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]: begin
            res_if.ready <= 1'b1;
          end
          [70:94]: begin
            res_if.ready <= 1'b0;
          end
          default: begin
            res_if.ready <= 1'b0;
            stall_left <= $urandom_range(20, 80);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [MOD_W-1:0] phase_mod [10] = '{11'd1, 11'd2, 11'd0, 11'd5, 11'd16, 11'd37,
                                        11'd2047, 11'd128, 11'd3, 11'd1024};
    answer_t typed;
    rst_n        <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.func  <= FN_SEARCH;
    req_if.key   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    empty_table(MOD_RESET);

    // reset table size 1024: collisions on home slot 0, top key, unused code
    plan.push_back('{0, 0, FN_SEARCH, 0,       1, ST_ABSENT,   0});
    plan.push_back('{0, 0, FN_INSERT, 0,       1, ST_ADDED,    1});
    plan.push_back('{0, 0, FN_INSERT, 0,       1, ST_PRESENT,  1});
    plan.push_back('{0, 0, FN_INSERT, KEY_TOP, 1, ST_ADDED,    2});
    plan.push_back('{0, 0, FN_INSERT, 1024,    1, ST_ADDED,    3});
    plan.push_back('{0, 0, FN_INSERT, 2048,    1, ST_ADDED,    4});
    plan.push_back('{0, 0, FN_SPARE,  0,       1, ST_PRESENT,  4});
    plan.push_back('{0, 0, FN_REMOVE, 0,       1, ST_REMOVED,  3});
    plan.push_back('{0, 0, FN_SEARCH, 2048,    0, 0, 0});
    plan.push_back('{0, 0, FN_REMOVE, 0,       1, ST_NOTFOUND, 3});
    plan.push_back('{0, 0, FN_INSERT, 1023,    0, 0, 0});
    plan.push_back('{0, 0, FN_INSERT, 2047,    0, 0, 0});
    plan.push_back('{0, 0, FN_REMOVE, 1023,    0, 0, 0});
    plan.push_back('{0, 0, FN_SEARCH, 2047,    0, 0, 0});
    // two slots: full table, present key when full
    plan.push_back('{1, 11'd2, 0, 0, 0, 0, 0});
    plan.push_back('{0, 0, FN_INSERT, 5,       1, ST_ADDED,    1});
    plan.push_back('{0, 0, FN_INSERT, 7,       1, ST_ADDED,    2});
    plan.push_back('{0, 0, FN_INSERT, 9,       1, ST_FULL,     2});
    plan.push_back('{0, 0, FN_INSERT, 5,       1, ST_PRESENT,  2});
    plan.push_back('{0, 0, FN_REMOVE, 5,       1, ST_REMOVED,  1});
    plan.push_back('{0, 0, FN_SEARCH, 7,       0, 0, 0});
    // modulus zero behaves as one slot
    plan.push_back('{1, 11'd0, 0, 0, 0, 0, 0});
    plan.push_back('{0, 0, FN_INSERT, 3,       1, ST_ADDED,    1});
    plan.push_back('{0, 0, FN_INSERT, 4,       1, ST_FULL,     1});
    plan.push_back('{0, 0, FN_REMOVE, 3,       1, ST_REMOVED,  0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_modulus(plan[i].modulus);
      end else begin
        typed.status    = plan[i].status;
        typed.occupancy = plan[i].occupancy;
        send_request(plan[i].func, plan[i].key, plan[i].fixed, typed);
      end
    end

    foreach (phase_mod[p]) begin
      write_modulus(phase_mod[p]);
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        send_request(draw_func(), draw_key(), 1'b0, typed);
      end
    end
    calm = 1'b0;
    req_if.valid <= 1'b0;

    wait (awaited_answers.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && awaited_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
